[design/assert_macros.svh]
// Shared assertion macros for the RTL in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge except while reset is high.
`define ASSERT_RST(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

[design/rdc_pkg.sv]
`default_nettype none

package rdc_pkg;

   localparam int POS_W = 17;
   localparam int VAL_W = 16;
   localparam int CNT_W = 17;
   localparam int LEN_W = 17;

   localparam int DEF_MAX_LENGTH = 65536;
   localparam int DEF_VALUE_BITS = 16;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic             command;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] range_left;
      logic [POS_W-1:0] range_right;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] distinct_count;
      logic             range_error;
   } rsp_type;

endpackage

`default_nettype wire

[design/range_distinct_count_core.sv]
// Load: empties the window, stores an in-range element, is ready again; no result.
// Query: steps the window to the range, then gives the result; invalid ones skip to it.
// Each step is an element-store read followed by a count-store read-modify-write.
// One transaction at a time; a finished result waits in the output register.
// After reset the count store is cleared, one entry a cycle, across all 2**VALUE_BITS
// entries (65536 by default) while req_stall is high; csr writes are taken throughout.
`default_nettype none

module range_distinct_count_core #(
   parameter int MAX_LENGTH = rdc_pkg::DEF_MAX_LENGTH,
   parameter int VALUE_BITS = rdc_pkg::DEF_VALUE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire rdc_pkg::req_type       req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rdc_pkg::rsp_type            rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [rdc_pkg::LEN_W-1:0] csr_wdata
);
   import rdc_pkg::*;

   `include "assert_macros.svh"

   localparam int AW = $clog2(MAX_LENGTH);
   localparam int VALUE_SPAN = 2 ** VALUE_BITS;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PICK,
      ST_ELEM,
      ST_COUNT,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [POS_W-1:0]       window_low_ff, window_low_in;
   logic [POS_W-1:0]       window_high_ff, window_high_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic [LEN_W-1:0]       array_length_ff, array_length_in;
   req_type                req_ff, req_in;
   logic                   op_add_ff, op_add_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [VALUE_BITS-1:0]  elem_mem [MAX_LENGTH];
   logic [VALUE_BITS-1:0]  elem_rd_data_ff;
   logic                   elem_rd_en;
   logic [AW-1:0]          elem_rd_addr;
   logic                   elem_we;
   logic [AW-1:0]          elem_wr_addr;

   logic [CNT_W-1:0]       cnt_mem [VALUE_SPAN];
   logic [CNT_W-1:0]       cnt_rd_data_ff;
   logic                   cnt_rd_en;
   logic                   cnt_we;
   logic [VALUE_BITS-1:0]  cnt_wr_addr;
   logic [CNT_W-1:0]       cnt_wr_data;

   logic [POS_W-1:0]       limit;
   logic                   query_bad;
   logic                   load_pos_ok;
   logic                   step_go;
   logic [POS_W-1:0]       step_pos;

   // Lengths beyond the store are clamped to its size.
   always_comb begin
      if (32'(array_length_ff) > 32'(MAX_LENGTH)) begin
         limit = POS_W'(MAX_LENGTH);
      end else begin
         limit = array_length_ff;
      end
   end

   assign query_bad = (req_payload.range_left == '0)
                   || (req_payload.range_right > limit)
                   || ({1'b0, req_payload.range_left}
                       > ({1'b0, req_payload.range_right} + (POS_W+1)'(1)));

   assign load_pos_ok = (req_ff.position != '0)
                     && (32'(req_ff.position) <= 32'(MAX_LENGTH));

   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      window_low_in   = window_low_ff;
      window_high_in  = window_high_ff;
      total_in        = total_ff;
      array_length_in = array_length_ff;
      req_in          = req_ff;
      op_add_in       = op_add_ff;
      err_in          = err_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_in          = rsp_ff;
      elem_rd_en      = 1'b0;
      elem_we         = 1'b0;
      elem_wr_addr    = AW'(req_ff.position - POS_W'(1));
      cnt_rd_en       = 1'b0;
      cnt_we          = 1'b0;
      cnt_wr_addr     = elem_rd_data_ff;
      cnt_wr_data     = '0;
      step_go         = 1'b0;
      step_pos        = '0;

      if (csr_valid) begin
         array_length_in = csr_wdata;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_we      = 1'b1;
            cnt_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + VALUE_BITS'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_payload;
               if (req_payload.command == CMD_QUERY && query_bad) begin
                  err_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  err_in   = 1'b0;
                  state_in = ST_PICK;
               end
            end
         end
         ST_PICK: begin
            // Grow before shrinking so no count is ever taken below zero.
            if (req_ff.command == CMD_LOAD) begin
               if (window_high_ff >= window_low_ff) begin
                  step_go        = 1'b1;
                  op_add_in      = 1'b0;
                  step_pos       = window_high_ff;
                  window_high_in = window_high_ff - POS_W'(1);
               end else begin
                  elem_we        = load_pos_ok;
                  window_low_in  = POS_W'(1);
                  window_high_in = '0;
                  total_in       = '0;
                  state_in       = ST_IDLE;
               end
            end else if (window_high_ff < req_ff.range_right) begin
               step_go        = 1'b1;
               op_add_in      = 1'b1;
               step_pos       = window_high_ff + POS_W'(1);
               window_high_in = step_pos;
            end else if (window_low_ff > req_ff.range_left) begin
               step_go       = 1'b1;
               op_add_in     = 1'b1;
               step_pos      = window_low_ff - POS_W'(1);
               window_low_in = step_pos;
            end else if (window_high_ff > req_ff.range_right) begin
               step_go        = 1'b1;
               op_add_in      = 1'b0;
               step_pos       = window_high_ff;
               window_high_in = window_high_ff - POS_W'(1);
            end else if (window_low_ff < req_ff.range_left) begin
               step_go       = 1'b1;
               op_add_in     = 1'b0;
               step_pos      = window_low_ff;
               window_low_in = window_low_ff + POS_W'(1);
            end else begin
               state_in = ST_FINISH;
            end
            if (step_go) begin
               elem_rd_en = 1'b1;
               state_in   = ST_ELEM;
            end
         end
         ST_ELEM: begin
            cnt_rd_en = 1'b1;
            state_in  = ST_COUNT;
         end
         ST_COUNT: begin
            if (op_add_ff) begin
               cnt_we      = 1'b1;
               cnt_wr_data = cnt_rd_data_ff + CNT_W'(1);
               if (cnt_rd_data_ff == '0) begin
                  total_in = total_ff + CNT_W'(1);
               end
            end else if (cnt_rd_data_ff != '0) begin
               cnt_we      = 1'b1;
               cnt_wr_data = cnt_rd_data_ff - CNT_W'(1);
               if (cnt_rd_data_ff == CNT_W'(1)) begin
                  total_in = total_ff - CNT_W'(1);
               end
            end
            state_in = ST_PICK;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_in.range_error         = err_ff;
               rsp_in.distinct_count      = err_ff ? '0 : total_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign elem_rd_addr = AW'(step_pos - POS_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         window_low_ff   <= POS_W'(1);
         window_high_ff  <= '0;
         total_ff        <= '0;
         array_length_ff <= '0;
         op_add_ff       <= 1'b0;
         err_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         window_low_ff   <= window_low_in;
         window_high_ff  <= window_high_in;
         total_ff        <= total_in;
         array_length_ff <= array_length_in;
         op_add_ff       <= op_add_in;
         err_ff          <= err_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_wr_addr] <= VALUE_BITS'(req_ff.value);
      end
      if (elem_rd_en) begin
         elem_rd_data_ff <= elem_mem[elem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wr_addr] <= cnt_wr_data;
      end
      if (cnt_rd_en) begin
         cnt_rd_data_ff <= cnt_mem[elem_rd_data_ff];
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   // The window never holds fewer than zero elements.
   `ASSERT_RST(a_window_ordered, clock, reset,
      ({1'b0, window_low_ff} <= ({1'b0, window_high_ff} + (POS_W+1)'(1))))

   // Between steps there cannot be more distinct values than elements in the window.
   // During a removal the window shrinks when PICK ends; the total follows after COUNT.
   `ASSERT_RST(a_total_bounded, clock, reset,
      (state_ff != ST_ELEM && state_ff != ST_COUNT)
      |-> (({1'b0, total_ff} + {1'b0, window_low_ff})
           <= ({1'b0, window_high_ff} + (POS_W+1)'(1))))

   // An error result always carries a zero count.
   `ASSERT_RST(a_error_zero, clock, reset,
      (rsp_valid_ff && rsp_ff.range_error) |-> (rsp_ff.distinct_count == '0))

   // A finished load leaves the window empty with no distinct values.
   `ASSERT_RST(a_load_empties, clock, reset,
      (state_ff == ST_PICK && req_ff.command == CMD_LOAD && state_in == ST_IDLE)
      |=> (total_ff == '0 && window_high_ff == '0))

endmodule

`default_nettype wire

[tb/range_distinct_count_core_tb.sv]
`default_nettype none

module range_distinct_count_core_tb;
   import rdc_pkg::*;

   localparam int STORE_DEPTH  = DEF_MAX_LENGTH;
   localparam int VALUE_SPAN   = 1 << DEF_VALUE_BITS;
   localparam int POS_MAX      = (1 << POS_W) - 1;
   localparam int IDLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS = 950;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_payload;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [LEN_W-1:0]     csr_wdata;

   range_distinct_count_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   // Shadow copy of the array, the per-value tallies and the sliding window.
   logic [VAL_W-1:0] elem_mem [STORE_DEPTH];
   int unsigned      value_tally [VALUE_SPAN];
   bit               loaded [STORE_DEPTH];
   int unsigned      win_lo = 1;
   int unsigned      win_hi = 0;
   int unsigned      distinct_now = 0;
   int unsigned      length_reg = 0;
   int unsigned      loaded_prefix = 0;
   int unsigned      load_span = 0;

   rsp_type          counts_due [$];
   int               errors = 0;
   int               items_sent = 0;
   int               idle_cycles = 0;
   int               hold_left = 0;
   int               stall_run = 0;
   bit               stall_on = 0;
   bit               req_up = 0;
   int               burst_left = 0;
   bit               steady_send = 0;
   logic [VAL_W-1:0] value_pool [16];
   int               pool_size = 1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void add_position(int unsigned p);
      logic [VAL_W-1:0] v;
      v = elem_mem[p-1];
      if (value_tally[v] == 0) distinct_now++;
      value_tally[v]++;
   endfunction

   function automatic void drop_position(int unsigned p);
      logic [VAL_W-1:0] v;
      v = elem_mem[p-1];
      if (value_tally[v] != 0) begin
         value_tally[v]--;
         if (value_tally[v] == 0) distinct_now--;
      end
   endfunction

   function automatic void predict_load(int unsigned pos, logic [VAL_W-1:0] val);
      load_span = (win_hi >= win_lo) ? win_hi - win_lo + 1 : 0;
      while (win_hi >= win_lo) begin
         drop_position(win_hi);
         win_hi--;
      end
      win_lo = 1;
      win_hi = 0;
      distinct_now = 0;
      if (pos >= 1 && pos <= STORE_DEPTH) begin
         elem_mem[pos-1] = val;
         loaded[pos-1] = 1'b1;
         while (loaded_prefix < STORE_DEPTH && loaded[loaded_prefix]) loaded_prefix++;
      end
   endfunction

   function automatic void predict_count(int unsigned lft, int unsigned rgt);
      rsp_type     r;
      int unsigned bound;
      load_span = 0;
      bound = (length_reg > STORE_DEPTH) ? STORE_DEPTH : length_reg;
      if (lft < 1 || rgt > bound || lft > rgt + 1) begin
         r.distinct_count = '0;
         r.range_error    = 1'b1;
      end else begin
         // Grow before shrinking so the window never turns inside out.
         while (win_hi < rgt) begin
            win_hi++;
            add_position(win_hi);
         end
         while (win_lo > lft) begin
            win_lo--;
            add_position(win_lo);
         end
         while (win_hi > rgt) begin
            drop_position(win_hi);
            win_hi--;
         end
         while (win_lo < lft) begin
            drop_position(win_lo);
            win_lo++;
         end
         r.distinct_count = CNT_W'(distinct_now);
         r.range_error    = 1'b0;
      end
      counts_due.push_back(r);
   endfunction

   task automatic release_req();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 0;
      end
   endtask

   // Offers one transaction and returns in the time step it is accepted.
   task automatic send_item(input req_type t);
      int gap;
      if (!steady_send && burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
         gap = $urandom_range(1, 8);
         release_req();
         repeat (gap) @(posedge clock);
      end else if (!req_up) begin
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= t;
      req_up = 1;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (t.command == CMD_LOAD) predict_load(t.position, t.value);
      else predict_count(t.range_left, t.range_right);
      items_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   task automatic send_load(input int unsigned pos, input logic [VAL_W-1:0] val);
      req_type t;
      t.command     = CMD_LOAD;
      t.position    = POS_W'(pos);
      t.value       = val;
      t.range_left  = POS_W'($urandom_range(0, POS_MAX));
      t.range_right = POS_W'($urandom_range(0, POS_MAX));
      send_item(t);
   endtask

   task automatic send_query(input int unsigned lft, input int unsigned rgt);
      req_type t;
      t.command     = CMD_QUERY;
      t.position    = POS_W'($urandom_range(0, POS_MAX));
      t.value       = VAL_W'($urandom_range(0, VALUE_SPAN - 1));
      t.range_left  = POS_W'(lft);
      t.range_right = POS_W'(rgt);
      send_item(t);
   endtask

   // Waits until every result is in and any trailing load has emptied its window.
   task automatic settle();
      release_req();
      while (counts_due.size() != 0) @(posedge clock);
      repeat (3 * load_span + 16) @(posedge clock);
   endtask

   task automatic write_length(input int unsigned len);
      settle();
      csr_valid <= 1'b1;
      csr_wdata <= LEN_W'(len);
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      length_reg = len;
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      if ($urandom_range(0, 3) == 0) return VAL_W'($urandom_range(0, VALUE_SPAN - 1));
      return value_pool[$urandom_range(0, pool_size - 1)];
   endfunction

   task automatic random_query();
      int unsigned bound;
      int unsigned top;
      int unsigned rgt;
      int unsigned lft;
      int          kind;
      bound = (length_reg > STORE_DEPTH) ? STORE_DEPTH : length_reg;
      top = (bound < loaded_prefix) ? bound : loaded_prefix;
      kind = $urandom_range(0, 19);
      if (kind < 16) begin
         // Only ranges over loaded positions, so no unwritten element is ever read.
         rgt = $urandom_range(0, top);
         lft = $urandom_range(1, rgt + 1);
      end else if (kind == 16) begin
         lft = 0;
         rgt = $urandom_range(0, POS_MAX);
      end else if (kind == 17) begin
         rgt = $urandom_range(bound + 1, POS_MAX);
         lft = $urandom_range(0, POS_MAX);
      end else begin
         rgt = $urandom_range(0, bound);
         lft = $urandom_range(rgt + 2, POS_MAX);
      end
      send_query(lft, rgt);
   endtask

   task automatic noise_load();
      int unsigned pos;
      case ($urandom_range(0, 2))
         0:       pos = 0;
         1:       pos = $urandom_range(STORE_DEPTH + 1, POS_MAX);
         default: pos = $urandom_range(1, STORE_DEPTH);
      endcase
      send_load(pos, VAL_W'($urandom_range(0, VALUE_SPAN - 1)));
   endtask

   task automatic test_empty_store();
      send_query(1, 0);
      send_query(1, 1);
      send_query(0, 0);
      send_query(3, 1);
   endtask

   task automatic test_load_edges();
      send_load(0, 16'hFFFF);
      send_load(POS_MAX, 16'h1234);
      send_load(STORE_DEPTH + 1, 16'h5555);
      send_load(STORE_DEPTH, 16'hFFFF);
      send_load(1, 16'h0000);
      send_load(2, 16'hFFFF);
      send_load(3, 16'h0000);
      send_load(4, 16'hAAAA);
      write_length(4);
   endtask

   task automatic test_small_ranges();
      send_query(1, 4);
      send_query(2, 3);
      send_query(4, 4);
      send_query(5, 4);
      send_query(6, 4);
      send_query(1, 5);
      send_query(STORE_DEPTH, POS_MAX);
      send_query(POS_MAX, 0);
      send_load(2, 16'h0000);
      send_query(1, 4);
   endtask

   task automatic test_length_clamp();
      write_length(POS_MAX);
      send_query(1, STORE_DEPTH + 1);
      send_query(STORE_DEPTH + 2, STORE_DEPTH);
      send_query(1, 3);
      write_length(STORE_DEPTH);
      send_query(2, 0);
   endtask

   task automatic test_random_phases();
      int          target;
      int          span;
      int          fill_to;
      int          n_queries;
      int          len_case;
      int unsigned len;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         span = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 48);
         pool_size = $urandom_range(1, 16);
         foreach (value_pool[i]) value_pool[i] = VAL_W'($urandom_range(0, VALUE_SPAN - 1));
         len_case = $urandom_range(0, 7);
         case (len_case)
            0:       len = 0;
            1:       len = STORE_DEPTH;
            2:       len = POS_MAX;
            3:       len = span / 2;
            default: len = span + $urandom_range(0, 4);
         endcase
         write_length(len);
         // Mostly a full fill of the front of the array; now and then a broken one.
         fill_to = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span) : span;
         for (int k = 1; k <= fill_to; k++) begin
            if ($urandom_range(0, 19) == 0) noise_load();
            send_load(k, pick_value());
         end
         n_queries = $urandom_range(15, 40);
         repeat (n_queries) begin
            if ($urandom_range(0, 24) == 0) noise_load();
            else random_query();
         end
      end
   endtask

   task automatic test_backpressure();
      // The receiver holds off while the sender keeps offering back to back.
      hold_left = 400;
      steady_send = 1;
      repeat (16) random_query();
      steady_send = 0;
      settle();
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         if (stall_run == 0) begin
            stall_on = !stall_on;
            stall_run = stall_on ? $urandom_range(1, 6) : $urandom_range(1, 40);
         end
         stall_run--;
         rsp_stall <= stall_on;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (counts_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: count %0d error %b", $time,
                     rsp_payload.distinct_count, rsp_payload.range_error);
         end else begin
            want = counts_due.pop_front();
            if (rsp_payload.distinct_count !== want.distinct_count ||
                rsp_payload.range_error !== want.range_error) begin
               errors++;
               $display("%0t: mismatch: expected count %0d error %b, got count %0d error %b",
                        $time, want.distinct_count, want.range_error,
                        rsp_payload.distinct_count, rsp_payload.range_error);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      csr_valid   = 1'b0;
      csr_wdata   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_load_edges();
      test_small_ranges();
      test_length_clamp();
      test_backpressure();
      test_random_phases();
      test_backpressure();

      settle();
      if (errors == 0 && counts_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
